### rtl/spool_pkg.sv
// ----------------------------------------------------------------------------
// spool_pkg: shared definitions for the server pool core
// Sizes, status codes, opcodes, sequencer states and the active-count clamp.
// ----------------------------------------------------------------------------
package spool_pkg;

  localparam int MAX_SERVERS = 8;
  localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
  localparam int CFG_W       = 4;
  localparam int TIME_W      = 32;
  localparam int CUST_W      = 16;
  localparam int SRC_W       = 4;
  localparam int STAT_W      = 2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

  // Request opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STOP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FREE = 3'b010,
    ST_MIN  = 3'b100
  } state_t;

  // A zero count acts as one server, anything above the pool size as the
  // whole pool.
  function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_SERVERS) begin
      r = CNT_W'(MAX_SERVERS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

### rtl/server_pool_round_robin_earliest_release_core.sv
// ----------------------------------------------------------------------------
// server_pool_round_robin_earliest_release_core
// Round-robin server allocation with an earliest-release finder, built
// around one entry-wide compare unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake           Ports
//  -------   -----------------   -----------------------------------------
//  request   start & !busy       in_opcode, in_customer_id, in_source_no,
//                                in_start_time, in_service_duration
//  result    out_valid (1 cyc)   out_status ... out_busy_count
//  config    cfg_we              cfg_wdata (servers in use)
//
// A stop request goes from idle to the earliest-release scan; a start request
// first runs the free-server search and then the scan. The scan looks at the
// N active servers, one server per cycle; the search visits F (1..N) ring
// positions, one per cycle. The result strobe follows in the cycle after the
// last scan step, and busy is already low in that cycle.
// Reset is synchronous and active low; it empties the pool and sets eight
// active servers. A configuration write empties the pool the same way.
// The receiver cannot stall results: each result is shown for exactly one
// cycle and the block never waits on the result side.
// ----------------------------------------------------------------------------
module server_pool_round_robin_earliest_release_core
  import spool_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_opcode,
  input  logic [CUST_W-1:0]    in_customer_id,
  input  logic [SRC_W-1:0]     in_source_no,
  input  logic [TIME_W-1:0]    in_start_time,
  input  logic [TIME_W-1:0]    in_service_duration,
  // Configuration port
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // Result channel
  output logic                 out_valid,
  output logic [STAT_W-1:0]    out_status,
  output logic [2:0]           out_server_index,
  output logic [CUST_W-1:0]    out_released_customer_id,
  output logic [SRC_W-1:0]     out_released_source_no,
  output logic                 out_next_event_valid,
  output logic [2:0]           out_next_event_index,
  output logic [TIME_W-1:0]    out_next_event_time,
  output logic [3:0]           out_busy_count
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t               state_r, state_nxt;

  logic [CFG_W-1:0]     servers_in_use_r;
  logic [MAX_SERVERS-1:0] busy_r;
  logic [TIME_W-1:0]    rel_time_r [MAX_SERVERS];
  logic [CUST_W-1:0]    cust_r     [MAX_SERVERS];
  logic [SRC_W-1:0]     src_r      [MAX_SERVERS];
  logic [IDX_W-1:0]     ring_r;
  logic [CNT_W-1:0]     busy_total_r;
  logic                 earliest_valid_r;
  logic [IDX_W-1:0]     earliest_index_r;

  // Latched request fields.
  logic [CUST_W-1:0]    req_cust_r;
  logic [SRC_W-1:0]     req_src_r;
  logic [TIME_W-1:0]    req_start_r;
  logic [TIME_W-1:0]    req_dur_r;

  // Free-server search.
  logic [IDX_W-1:0]     cand_r;
  logic [CNT_W-1:0]     step_r;

  // Earliest-release scan.
  logic [IDX_W-1:0]     scan_idx_r;
  logic                 best_valid_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [TIME_W-1:0]    best_time_r;

  // Result fields decided before the scan.
  logic [STAT_W-1:0]    res_status_r;
  logic [IDX_W-1:0]     res_index_r;
  logic [CUST_W-1:0]    res_cust_r;
  logic [SRC_W-1:0]     res_src_r;

  // Output registers.
  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [2:0]           out_server_index_r;
  logic [CUST_W-1:0]    out_cust_r;
  logic [SRC_W-1:0]     out_src_r;
  logic                 out_ne_valid_r;
  logic [2:0]           out_ne_index_r;
  logic [TIME_W-1:0]    out_ne_time_r;
  logic [3:0]           out_busy_count_r;

  // --------------------------------------------------------------------------
  // Shared combinational helpers
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]     n_act;
  logic [IDX_W-1:0]     n_last;
  logic [CNT_W-1:0]     cfg_n;
  logic                 accept;
  logic [IDX_W-1:0]     ring_succ;
  logic [IDX_W-1:0]     cand_succ;
  logic [TIME_W:0]      sum_w;
  logic [TIME_W-1:0]    rel_sat;
  logic                 stop_ok;
  logic [TIME_W-1:0]    rt_cur;
  logic                 take;
  logic                 min_valid;
  logic [IDX_W-1:0]     min_idx;
  logic [TIME_W-1:0]    min_time;
  logic                 scan_last;

  assign n_act   = active_count(servers_in_use_r);
  assign n_last  = IDX_W'(n_act - CNT_W'(1));
  assign cfg_n   = active_count(cfg_wdata);
  assign accept  = start && (state_r == ST_IDLE);

  // Next ring position, wrapping at the last active server.
  assign ring_succ = (ring_r == n_last) ? '0 : IDX_W'(ring_r + IDX_W'(1));
  assign cand_succ = (cand_r == n_last) ? '0 : IDX_W'(cand_r + IDX_W'(1));

  // Release time, saturated at all ones.
  assign sum_w   = {1'b0, req_start_r} + {1'b0, req_dur_r};
  assign rel_sat = sum_w[TIME_W] ? '1 : sum_w[TIME_W-1:0];

  // A stop frees the tracked earliest server if it is still a live one.
  assign stop_ok = earliest_valid_r && (CNT_W'(earliest_index_r) < n_act)
                   && busy_r[earliest_index_r];

  // One compare per cycle: the scanned entry against the best so far.
  assign rt_cur    = rel_time_r[scan_idx_r];
  assign take      = busy_r[scan_idx_r] && (!best_valid_r || (rt_cur < best_time_r));
  assign min_valid = best_valid_r || take;
  assign min_idx   = take ? scan_idx_r : best_idx_r;
  assign min_time  = take ? rt_cur : best_time_r;
  assign scan_last = (scan_idx_r == n_last);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_opcode == OP_START) ? ST_FREE : ST_MIN;
        end
      end
      ST_FREE: begin
        if (!busy_r[cand_r] || (step_r == n_act)) begin
          state_nxt = ST_MIN;
        end
      end
      ST_MIN: begin
        if (scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      servers_in_use_r <= CFG_W'(8);
      busy_r           <= '0;
      ring_r           <= IDX_W'(CNT_W'(MAX_SERVERS) - CNT_W'(1));
      busy_total_r     <= '0;
      earliest_valid_r <= 1'b0;
      earliest_index_r <= '0;
      out_valid_r      <= 1'b0;
    end else if (cfg_we) begin
      // A new pool size empties the pool.
      servers_in_use_r <= cfg_wdata;
      busy_r           <= '0;
      ring_r           <= IDX_W'(cfg_n - CNT_W'(1));
      busy_total_r     <= '0;
      earliest_valid_r <= 1'b0;
      earliest_index_r <= '0;
      out_valid_r      <= 1'b0;
      state_r          <= ST_IDLE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_opcode == OP_STOP) && stop_ok) begin
            busy_r[earliest_index_r] <= 1'b0;
            if (busy_total_r != '0) begin
              busy_total_r <= busy_total_r - CNT_W'(1);
            end
          end
          if (accept) begin
            // The tracked earliest server is rebuilt by the scan.
            earliest_valid_r <= 1'b0;
          end
        end
        ST_FREE: begin
          if (!busy_r[cand_r]) begin
            busy_r[cand_r] <= 1'b1;
            ring_r         <= cand_r;
            busy_total_r   <= busy_total_r + CNT_W'(1);
          end
        end
        ST_MIN: begin
          if (scan_last) begin
            earliest_valid_r <= min_valid;
            earliest_index_r <= min_valid ? min_idx : '0;
            out_valid_r      <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_cust_r   <= in_customer_id;
          req_src_r    <= in_source_no;
          req_start_r  <= in_start_time;
          req_dur_r    <= in_service_duration;
          cand_r       <= ring_succ;
          step_r       <= CNT_W'(1);
          scan_idx_r   <= '0;
          best_valid_r <= 1'b0;
          best_idx_r   <= '0;
          res_index_r  <= '0;
          res_cust_r   <= '0;
          res_src_r    <= '0;
          res_status_r <= STAT_DONE;
          if (in_opcode == OP_STOP) begin
            if (stop_ok) begin
              res_index_r <= earliest_index_r;
              res_cust_r  <= cust_r[earliest_index_r];
              res_src_r   <= src_r[earliest_index_r];
            end else begin
              res_status_r <= STAT_EMPTY;
            end
          end
        end
      end
      ST_FREE: begin
        if (!busy_r[cand_r]) begin
          rel_time_r[cand_r] <= rel_sat;
          cust_r[cand_r]     <= req_cust_r;
          src_r[cand_r]      <= req_src_r;
          res_index_r        <= cand_r;
        end else if (step_r == n_act) begin
          res_status_r <= STAT_FULL;
        end else begin
          cand_r <= cand_succ;
          step_r <= step_r + CNT_W'(1);
        end
      end
      ST_MIN: begin
        best_valid_r <= min_valid;
        best_idx_r   <= min_idx;
        best_time_r  <= min_time;
        scan_idx_r   <= IDX_W'(scan_idx_r + IDX_W'(1));
        if (scan_last) begin
          out_status_r       <= res_status_r;
          out_server_index_r <= 3'(res_index_r);
          out_cust_r         <= res_cust_r;
          out_src_r          <= res_src_r;
          out_ne_valid_r     <= min_valid;
          out_ne_index_r     <= min_valid ? 3'(min_idx) : 3'd0;
          out_ne_time_r      <= min_valid ? min_time : '1;
          out_busy_count_r   <= 4'(busy_total_r);
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign busy                     = (state_r != ST_IDLE);
  assign out_valid                = out_valid_r;
  assign out_status               = out_status_r;
  assign out_server_index         = out_server_index_r;
  assign out_released_customer_id = out_cust_r;
  assign out_released_source_no   = out_src_r;
  assign out_next_event_valid     = out_ne_valid_r;
  assign out_next_event_index     = out_ne_index_r;
  assign out_next_event_time      = out_ne_time_r;
  assign out_busy_count           = out_busy_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The busy counter always matches the busy flags.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    busy_total_r == CNT_W'($countones(busy_r)))
    else $error("busy count does not match busy flags");

  // At rest, the tracked earliest server is a busy one.
  a_earliest_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && earliest_valid_r) |-> busy_r[earliest_index_r])
    else $error("earliest server is not busy");

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_we) |=> busy)
    else $error("request accepted but block not busy");

  // The result strobe lasts a single cycle.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // A result comes only at the end of the earliest-release scan.
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_MIN))
    else $error("result without a finished scan");

endmodule
